// ----- hw/rtl/f2c_pkg.sv -----
// Shared types, codes and constants for the Frenet-to-Cartesian core.
`timescale 1ns / 1ps
package f2c_pkg;

  localparam int MAX_WAYPOINTS_DEF = 256;
  localparam int SQRT_STEPS = 36;   // result bits of the root
  localparam int DIV_STEPS  = 68;   // numerator bits of each division

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              op;
    logic [7:0]        entry_index;
    logic signed [31:0] entry_s;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic signed [31:0] query_s;
    logic signed [31:0] query_d;
  } f2c_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [1:0]         status;
  } f2c_out_t;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } f2c_wp_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_ZERO_LEN = 2'd2,
    ST_SAT      = 2'd3
  } f2c_status_t;

  typedef enum logic [1:0] {
    MS_SQ,   // dx*dx, dy*dy
    MS_X,    // ds*dx, d*dy
    MS_Y     // ds*dy, d*dx
  } f2c_mul_sel_t;

  typedef enum logic [1:0] {
    RK_ZERO,
    RK_EMPTY,
    RK_ZERO_LEN
  } f2c_res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_RD_PREV,
    S_CAP_PREV,
    S_CAP_NEXT,
    S_MUL_SQ,
    S_SUM_SQ,
    S_SQRT,
    S_CHK,
    S_NUM_X,
    S_DIV_X,
    S_MUL_Y,
    S_NUM_Y,
    S_DIV_Y,
    S_FIN,
    S_DONE
  } f2c_state_t;

  typedef struct packed {
    logic          take_query;
    logic          rd_en;
    logic          cap_prev;
    logic          cap_next;
    logic          mul;
    f2c_mul_sel_t  mul_sel;
    logic          sqrt_init;
    logic          sqrt_step;
    logic          div_init;
    logic          num_sub;
    logic          div_step;
    logic          store_qx;
    logic          finish;
    logic          res_load;
    f2c_res_kind_t res_kind;
    logic          out_load;
  } f2c_cmd_t;

  typedef struct packed {
    logic gt;        // query s above the entry just read
    logic len_zero;  // segment length is zero
    logic out_free;  // output register can take a result
  } f2c_sts_t;

endpackage

// ----- hw/rtl/f2c_wp_mem.sv -----
// Waypoint table: one write port, one registered read port.
`timescale 1ns / 1ps
module f2c_wp_mem #(
  parameter int DEPTH = f2c_pkg::MAX_WAYPOINTS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  f2c_pkg::f2c_wp_t  wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output f2c_pkg::f2c_wp_t  rd_data
);
  import f2c_pkg::*;

  f2c_wp_t mem [DEPTH];
  f2c_wp_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/f2c_ctrl.sv -----
// Controller: item handshake, waypoint count, segment search and step sequencing.
`timescale 1ns / 1ps
module f2c_ctrl #(
  parameter int MAX_WAYPOINTS = f2c_pkg::MAX_WAYPOINTS_DEF,
  localparam int AW = $clog2(MAX_WAYPOINTS),
  localparam int CW = $clog2(MAX_WAYPOINTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  f2c_pkg::f2c_in_t  in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [8:0]        cfg_data,
  input  f2c_pkg::f2c_sts_t sts,
  output f2c_pkg::f2c_cmd_t cmd,
  output logic [AW-1:0]     rd_addr,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr
);
  import f2c_pkg::*;

  f2c_state_t    state_r, state_nxt;
  logic [8:0]    count_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic [6:0]    step_r, step_nxt;

  logic [31:0]   n_w, ei_w, prev_inc_w, next_w, idx_w;
  logic [CW-1:0] n, idx_m1;
  logic          accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;

  assign n_w        = (32'(count_r) > MAX_WAYPOINTS) ? 32'(MAX_WAYPOINTS) : 32'(count_r);
  assign n          = n_w[CW-1:0];
  assign idx_w      = 32'(idx_r);
  assign idx_m1     = idx_r - 1'b1;
  assign prev_inc_w = 32'(prev_r) + 32'd1;
  assign next_w     = (prev_inc_w == n_w) ? 32'd0 : prev_inc_w;

  // slots beyond the table are dropped
  assign ei_w    = 32'(in_data.entry_index);
  assign wr_en   = accept && (in_data.op == OP_LOAD) && (ei_w < MAX_WAYPOINTS);
  assign wr_addr = ei_w[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      prev_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      prev_r  <= prev_nxt;
      step_r  <= step_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    prev_nxt  = prev_r;
    step_nxt  = step_r;
    cmd       = '0;
    rd_addr   = idx_w[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_LOAD) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RK_ZERO;
            state_nxt    = S_DONE;
          end else if (n == '0) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RK_EMPTY;
            state_nxt    = S_DONE;
          end else begin
            cmd.take_query = 1'b1;
            idx_nxt        = '0;
            pend_nxt       = 1'b0;
            prev_nxt       = '0;
            state_nxt      = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        // one read issued per cycle, each compared in the next cycle
        if (idx_r < n) begin
          cmd.rd_en = 1'b1;
          idx_nxt   = idx_r + 1'b1;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
        end
        if (pend_r) begin
          if (sts.gt) begin
            prev_nxt = idx_m1[AW-1:0];
          end
          if (!sts.gt || (idx_r == n)) begin
            state_nxt = S_RD_PREV;
          end
        end
      end
      S_RD_PREV: begin
        cmd.rd_en = 1'b1;
        rd_addr   = prev_r;
        state_nxt = S_CAP_PREV;
      end
      S_CAP_PREV: begin
        cmd.rd_en    = 1'b1;
        cmd.cap_prev = 1'b1;
        rd_addr      = next_w[AW-1:0];
        state_nxt    = S_CAP_NEXT;
      end
      S_CAP_NEXT: begin
        cmd.cap_next = 1'b1;
        state_nxt    = S_MUL_SQ;
      end
      S_MUL_SQ: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = MS_SQ;
        state_nxt   = S_SUM_SQ;
      end
      S_SUM_SQ: begin
        cmd.sqrt_init = 1'b1;
        step_nxt      = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step_r == 7'(SQRT_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_CHK;
        end else begin
          step_nxt  = step_r + 1'b1;
        end
      end
      S_CHK: begin
        if (sts.len_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RK_ZERO_LEN;
          state_nxt    = S_DONE;
        end else begin
          cmd.mul     = 1'b1;
          cmd.mul_sel = MS_X;
          state_nxt   = S_NUM_X;
        end
      end
      S_NUM_X: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV_X;
      end
      S_DIV_X: begin
        cmd.div_step = 1'b1;
        if (step_r == 7'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_MUL_Y;
        end else begin
          step_nxt  = step_r + 1'b1;
        end
      end
      S_MUL_Y: begin
        cmd.store_qx = 1'b1;
        cmd.mul      = 1'b1;
        cmd.mul_sel  = MS_Y;
        state_nxt    = S_NUM_Y;
      end
      S_NUM_Y: begin
        cmd.div_init = 1'b1;
        cmd.num_sub  = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV_Y;
      end
      S_DIV_Y: begin
        cmd.div_step = 1'b1;
        if (step_r == 7'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          step_nxt  = step_r + 1'b1;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/f2c_dpath.sv -----
// Datapath: segment registers, shared multipliers, root and divider units, output register.
`timescale 1ns / 1ps
module f2c_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  f2c_pkg::f2c_in_t  in_data,
  input  f2c_pkg::f2c_wp_t  rd_data,
  input  f2c_pkg::f2c_cmd_t cmd,
  output f2c_pkg::f2c_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output f2c_pkg::f2c_out_t out_data
);
  import f2c_pkg::*;

  logic signed [31:0] qs_r, qd_r, arcp_r, xp_r, yp_r;
  logic signed [32:0] dx_r, dy_r, ds_r;
  logic signed [65:0] p1_r, p2_r;
  logic [71:0]        rad_r;
  logic [37:0]        srem_r;
  logic [35:0]        root_r;
  logic [67:0]        dnum_r;
  logic [36:0]        drem_r;
  logic               neg_r;
  logic signed [41:0] qx_r;
  f2c_out_t           res_r, out_r;
  logic               out_valid_r;

  // multiplier operands
  logic signed [32:0] ma, mb, mc, md, d33;
  logic signed [65:0] prod1, prod2;

  assign d33 = 33'(qd_r);

  always_comb begin
    case (cmd.mul_sel)
      MS_X: begin
        ma = ds_r; mb = dx_r; mc = d33; md = dy_r;
      end
      MS_Y: begin
        ma = ds_r; mb = dy_r; mc = d33; md = dx_r;
      end
      default: begin
        ma = dx_r; mb = dx_r; mc = dy_r; md = dy_r;
      end
    endcase
  end

  assign prod1 = ma * mb;
  assign prod2 = mc * md;

  // sum of squares and numerators
  logic signed [66:0] sq_sum;
  logic signed [67:0] num;
  logic [67:0]        num_mag;

  assign sq_sum  = 67'(p1_r) + 67'(p2_r);
  assign num     = cmd.num_sub ? (68'(p1_r) - 68'(p2_r)) : (68'(p1_r) + 68'(p2_r));
  assign num_mag = num[67] ? 68'(-num) : 68'(num);

  // square root, two radicand bits per step
  logic [39:0] s_sh, s_trial, s_diff;
  logic        s_ge;

  assign s_sh    = {srem_r, rad_r[71:70]};
  assign s_trial = {2'b00, root_r, 2'b01};
  assign s_ge    = (s_sh >= s_trial);
  assign s_diff  = s_sh - s_trial;

  // restoring division, one quotient bit per step
  logic [37:0] d_sh, d_len, d_diff;
  logic        d_ge;

  assign d_sh   = {drem_r, dnum_r[67]};
  assign d_len  = {2'b00, root_r};
  assign d_ge   = (d_sh >= d_len);
  assign d_diff = d_sh - d_len;

  // quotient capped at 2^40, then signed
  logic [40:0]        qcap;
  logic signed [41:0] qsig;

  assign qcap = (dnum_r[67:40] != '0) ? {1'b1, 40'd0} : {1'b0, dnum_r[39:0]};
  assign qsig = neg_r ? -$signed({1'b0, qcap}) : $signed({1'b0, qcap});

  function automatic logic [32:0] sat32(input logic signed [42:0] v);
    logic [32:0] r;
    begin
      if (v > 43'sd2147483647) begin
        r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -43'sd2147483648) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, v[31:0]};
      end
      return r;
    end
  endfunction

  logic [32:0] rx_sat, ry_sat;

  assign rx_sat = sat32(43'(xp_r) + 43'(qx_r));
  assign ry_sat = sat32(43'(yp_r) + 43'(qsig));

  always_ff @(posedge clk) begin
    if (cmd.take_query) begin
      qs_r <= in_data.query_s;
      qd_r <= in_data.query_d;
    end
    if (cmd.cap_prev) begin
      arcp_r <= rd_data.s;
      xp_r   <= rd_data.x;
      yp_r   <= rd_data.y;
    end
    if (cmd.cap_next) begin
      dx_r <= 33'(rd_data.x) - 33'(xp_r);
      dy_r <= 33'(rd_data.y) - 33'(yp_r);
      ds_r <= 33'(qs_r) - 33'(arcp_r);
    end
    if (cmd.mul) begin
      p1_r <= prod1;
      p2_r <= prod2;
    end
    if (cmd.sqrt_init) begin
      rad_r  <= {6'd0, sq_sum[65:0]};
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[69:0], 2'b00};
      srem_r <= s_ge ? s_diff[37:0] : s_sh[37:0];
      root_r <= {root_r[34:0], s_ge};
    end
    if (cmd.div_init) begin
      dnum_r <= num_mag;
      drem_r <= '0;
      neg_r  <= num[67];
    end else if (cmd.div_step) begin
      dnum_r <= {dnum_r[66:0], d_ge};
      drem_r <= d_ge ? d_diff[36:0] : d_sh[36:0];
    end
    if (cmd.store_qx) begin
      qx_r <= qsig;
    end
    if (cmd.res_load) begin
      case (cmd.res_kind)
        RK_EMPTY: begin
          res_r <= '{out_x: '0, out_y: '0, status: ST_EMPTY};
        end
        RK_ZERO_LEN: begin
          res_r <= '{out_x: xp_r, out_y: yp_r, status: ST_ZERO_LEN};
        end
        default: begin
          res_r <= '{out_x: '0, out_y: '0, status: ST_OK};
        end
      endcase
    end else if (cmd.finish) begin
      res_r.out_x  <= rx_sat[31:0];
      res_r.out_y  <= ry_sat[31:0];
      res_r.status <= (rx_sat[32] || ry_sat[32]) ? ST_SAT : ST_OK;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.gt       = (qs_r > rd_data.s);
  assign sts.len_zero = (root_r == '0);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hw/rtl/frenet_to_cartesian_core.sv -----
// Top level of the Frenet-to-Cartesian waypoint interpolation core.
`timescale 1ns / 1ps
//
//  channel | direction | handshake             | carries
//  --------+-----------+-----------------------+-------------------------------
//  in_     | input     | in_valid / in_stall   | load entry or (s, d) query
//  out_    | output    | out_valid / out_stall | x, y and status, one per item
//  cfg_    | input     | cfg_valid / cfg_ready | waypoint count (9 bits)
//
//  Flow: a load or an empty-table query goes straight to its result. A query
//  for n waypoints in use runs a search over the one table read port, then
//  36 root steps and two 68-step divisions.
//  Reset: rst_n synchronous, clears control and the count; table undefined.
//  Stalls: one item in flight; out_stall holds a finished result in the output
//  register while the next item may already be taken.
module frenet_to_cartesian_core #(
  parameter int MAX_WAYPOINTS = f2c_pkg::MAX_WAYPOINTS_DEF,
  localparam int AW = $clog2(MAX_WAYPOINTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  f2c_pkg::f2c_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output f2c_pkg::f2c_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [8:0]        cfg_data
);
  import f2c_pkg::*;

  f2c_cmd_t      cmd;
  f2c_sts_t      sts;
  f2c_wp_t       rd_data, wr_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  assign wr_data = '{s: in_data.entry_s, x: in_data.entry_x, y: in_data.entry_y};

  // sequencer: owns the count, search index and step counter
  f2c_ctrl #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr)
  );

  // waypoint table, written on a load transfer
  f2c_wp_mem #(.DEPTH(MAX_WAYPOINTS)) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // arithmetic and the result register
  f2c_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .rd_data  (rd_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // one item at a time: a transfer in closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in flight");

  // a result handed over is presented next cycle
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  // table written only on a load transfer
  a_wr_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (in_valid && !in_stall && (in_data.op == OP_LOAD)))
    else $error("table write outside a load transfer");

endmodule

// ----- sim/frenet_to_cartesian_core_tb.sv -----
// Self-checking testbench for the Frenet-to-Cartesian waypoint core.
`timescale 1ns / 1ps
module frenet_to_cartesian_core_tb;
  import f2c_pkg::*;

  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int TARGET_ITEMS = 1350;
  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic signed [127:0] SAT_HI = 128'sd2147483647;
  localparam logic signed [127:0] SAT_LO = -SAT_HI - 128'sd1;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  f2c_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  f2c_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [8:0] cfg_data = '0;

  frenet_to_cartesian_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor's copy of the table and count
  logic [8:0]         wp_count;
  logic signed [31:0] wp_arc  [256];
  logic signed [31:0] wp_xpos [256];
  logic signed [31:0] wp_ypos [256];
  bit                 wp_written [256];

  f2c_out_t pending_pts[$];
  int  errors = 0;
  int  items_acc = 0;
  int  n_query = 0, n_load = 0, n_cfg = 0, n_sat = 0, n_zero = 0;
  int  cycles = 0;
  bit  calm = 1'b0;         // no new random gaps or stalls on either side while set
  bit  hold_done = 1'b0;

  function automatic f2c_out_t convert_point(input f2c_in_t it);
    f2c_out_t r;
    int n, prv, nxt;
    logic signed [127:0] s, d, dx, dy, sq, len, t, one, ds, rx, ry;
    bit sat;
    r = '0;
    sat = 1'b0;
    one = 128'sd1;
    if (it.op == OP_LOAD) begin
      wp_arc[it.entry_index]     = it.entry_s;
      wp_xpos[it.entry_index]    = it.entry_x;
      wp_ypos[it.entry_index]    = it.entry_y;
      wp_written[it.entry_index] = 1'b1;
      return r;
    end
    n = (wp_count > 256) ? 256 : int'(wp_count);
    if (n == 0) begin
      r.status = ST_EMPTY;
      return r;
    end
    s = it.query_s;
    d = it.query_d;
    prv = -1;
    while (prv < n - 1 && s > wp_arc[prv + 1]) prv++;
    if (prv < 0) prv = 0;
    nxt = (prv + 1) % n;
    dx = wp_xpos[nxt];
    dx = dx - wp_xpos[prv];
    dy = wp_ypos[nxt];
    dy = dy - wp_ypos[prv];
    sq = dx * dx + dy * dy;
    len = 0;
    for (int b = 35; b >= 0; b--) begin
      t = len | (one << b);
      if (t * t <= sq) len = t;
    end
    if (len == 0) begin
      r.out_x  = wp_xpos[prv];
      r.out_y  = wp_ypos[prv];
      r.status = ST_ZERO_LEN;
      return r;
    end
    ds = s - wp_arc[prv];
    rx = wp_xpos[prv];
    rx = rx + (ds * dx + d * dy) / len;   // signed division truncates to zero
    ry = wp_ypos[prv];
    ry = ry + (ds * dy - d * dx) / len;
    if (rx > SAT_HI) begin rx = SAT_HI; sat = 1'b1; end
    if (rx < SAT_LO) begin rx = SAT_LO; sat = 1'b1; end
    if (ry > SAT_HI) begin ry = SAT_HI; sat = 1'b1; end
    if (ry < SAT_LO) begin ry = SAT_LO; sat = 1'b1; end
    r.out_x  = rx[31:0];
    r.out_y  = ry[31:0];
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  function automatic f2c_in_t mk_load(logic [7:0] idx, logic [31:0] s, logic [31:0] x,
                                      logic [31:0] y);
    f2c_in_t it;
    it = '0;
    it.op = OP_LOAD;
    it.entry_index = idx;
    it.entry_s = s;
    it.entry_x = x;
    it.entry_y = y;
    return it;
  endfunction

  function automatic f2c_in_t mk_query(logic [31:0] s, logic [31:0] d);
    f2c_in_t it;
    it = '0;
    it.op = OP_QUERY;
    it.query_s = s;
    it.query_d = d;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one item, hold it until the transfer, then predict
  task automatic send_item(input f2c_in_t it, input bit typed, input f2c_out_t res);
    int gap;
    f2c_out_t p;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = convert_point(it);
    pending_pts.push_back(typed ? res : p);
    items_acc++;
    if (it.op == OP_LOAD) n_load++; else n_query++;
  endtask

  // always waits on the clock before it checks, so in_valid is driven once per step
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pts.size() != 0);
  endtask

  task automatic write_count(input logic [8:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    wp_count = v;
    n_cfg++;
  endtask

  function automatic bit table_ready();
    int n;
    n = (wp_count > 256) ? 256 : int'(wp_count);
    for (int i = 0; i < n; i++) if (!wp_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] spread(int w);
    return $urandom_range(0, 2 * w) - w;
  endfunction

  // receiver: random stalls, one long hold-off, checks every transfer
  int stall_left = 0;
  int hold_left  = 0;
  always @(posedge clk) begin
    f2c_out_t want;
    int r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_pts.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h status=%0d", $time,
                   out_data.out_x, out_data.out_y, out_data.status);
          errors++;
        end else begin
          want = pending_pts.pop_front();
          if (out_data.out_x !== want.out_x) begin
            $display("%0t: out_x expected %h actual %h", $time, want.out_x, out_data.out_x);
            errors++;
          end
          if (out_data.out_y !== want.out_y) begin
            $display("%0t: out_y expected %h actual %h", $time, want.out_y, out_data.out_y);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_data.status);
            errors++;
          end
          if (want.status == ST_SAT) n_sat++;
          if (want.status == ST_ZERO_LEN) n_zero++;
        end
      end
      if (!hold_done && items_acc >= 200) begin
        hold_done = 1'b1;
        hold_left = 700;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (calm || r < 75) out_stall <= 1'b0;
        else begin
          out_stall <= 1'b1;
          stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 80);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  typedef struct {
    bit         is_cfg;
    logic [8:0] cfg_val;
    f2c_in_t    item;
    bit         typed;
    f2c_out_t   res;
  } plan_row_t;

  function automatic plan_row_t row_item(f2c_in_t it, bit typed, f2c_out_t res);
    plan_row_t r;
    r.is_cfg = 1'b0; r.cfg_val = '0; r.item = it; r.typed = typed; r.res = res;
    return r;
  endfunction

  function automatic plan_row_t row_cfg(logic [8:0] v);
    plan_row_t r;
    r.is_cfg = 1'b1; r.cfg_val = v; r.item = '0; r.typed = 1'b0; r.res = '0;
    return r;
  endfunction

  plan_row_t plan[$];

  initial begin
    f2c_out_t zero_res, empty_res, zl_res, none;
    f2c_in_t it;
    int phase, n, nq, wsz;
    longint lo, hi, span, acc_s, acc_x, acc_y;
    bit sorted;

    for (int i = 0; i < 256; i++) begin
      wp_arc[i] = '0; wp_xpos[i] = '0; wp_ypos[i] = '0; wp_written[i] = 1'b0;
    end
    wp_count = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    zero_res  = '0;
    none      = '0;
    empty_res = '0; empty_res.status = ST_EMPTY;
    zl_res = '0; zl_res.out_x = 32'h03E8_0000; zl_res.out_y = 32'h07D0_0000;
    zl_res.status = ST_ZERO_LEN;

    // directed: empty table, load extremes, single waypoint, 3-4-5 segment,
    // clamp below the first entry, wrap past the last, saturation
    plan.push_back(row_item(mk_query(32'h0001_0000, 32'h0), 1, empty_res));
    plan.push_back(row_item(mk_load(8'd255, S32_MAX, S32_MIN, S32_MAX), 1, zero_res));
    plan.push_back(row_item(mk_load(8'd0, 32'h0, 32'h03E8_0000, 32'h07D0_0000), 1, zero_res));
    plan.push_back(row_cfg(9'd1));
    plan.push_back(row_item(mk_query(32'h0005_0000, 32'h0007_0000), 1, zl_res));
    plan.push_back(row_item(mk_load(8'd1, 32'h0005_0000, 32'h03EB_0000, 32'h07D4_0000), 1,
                            zero_res));
    plan.push_back(row_cfg(9'd2));
    plan.push_back(row_item(mk_query(32'h0002_0000, 32'h0), 0, none));
    plan.push_back(row_item(mk_query(32'h0003_8000, 32'hFFFE_0000), 0, none));
    plan.push_back(row_item(mk_query(S32_MIN, 32'h0), 0, none));
    plan.push_back(row_item(mk_query(S32_MAX, 32'h0001_0000), 0, none));
    plan.push_back(row_item(mk_query(32'h0001_0000, S32_MAX), 0, none));
    plan.push_back(row_item(mk_query(32'h0001_0000, S32_MIN), 0, none));
    plan.push_back(row_item(mk_load(8'd1, 32'h0005_0000, 32'h03E8_0000, 32'h07D0_0000), 1,
                            zero_res));
    plan.push_back(row_item(mk_query(32'h0001_0000, 32'h0), 0, none));
    plan.push_back(row_item(mk_load(8'd0, S32_MIN, S32_MAX, S32_MIN), 1, zero_res));
    plan.push_back(row_item(mk_load(8'd1, S32_MAX, S32_MIN, S32_MAX), 1, zero_res));
    plan.push_back(row_item(mk_query(32'h0, S32_MAX), 0, none));
    plan.push_back(row_item(mk_query(S32_MIN, S32_MIN), 0, none));
    plan.push_back(row_cfg(9'd0));
    plan.push_back(row_item(mk_query(S32_MAX, S32_MAX), 1, empty_res));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_count(plan[i].cfg_val);
      else send_item(plan[i].item, plan[i].typed, plan[i].res);
    end

    // random phases: build a table, set the count, then mostly queries
    phase = 0;
    while (items_acc < TARGET_ITEMS) begin
      case (phase)
        3:       n = 256;
        6:       n = 511;
        9:       n = 0;
        10:      n = 1;
        default: n = $urandom_range(2, 16);
      endcase
      calm   = (phase % 5 == 4);
      sorted = ($urandom_range(0, 5) != 0);
      drain();
      acc_s = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      acc_x = $signed(spread(32'h0400_0000));
      acc_y = $signed(spread(32'h0400_0000));
      for (int i = 0; i < ((n > 256) ? 256 : n); i++) begin
        if (sorted) begin
          it = mk_load(i[7:0], acc_s[31:0], acc_x[31:0], acc_y[31:0]);
          acc_s += $urandom_range(1, 32'h0008_0000);
          if ($urandom_range(0, 9) != 0) begin
            acc_x += $signed(spread(32'h0004_0000));
            acc_y += $signed(spread(32'h0004_0000));
          end
        end else begin
          it = mk_load(i[7:0], $urandom(), $urandom(), $urandom());
        end
        send_item(it, 0, none);
      end
      write_count(n[8:0]);
      nq = (n >= 256) ? 20 : 30;
      for (int q = 0; q < nq; q++) begin
        if ($urandom_range(0, 99) < 15) begin
          it = mk_load(8'($urandom_range(0, 255)), $urandom(), $urandom(), $urandom());
        end else if ($urandom_range(0, 99) < 75 && n > 0) begin
          lo = longint'(wp_arc[0]) - 32'h0002_0000;
          hi = longint'(wp_arc[((n > 256) ? 256 : n) - 1]) + 32'h0002_0000;
          if (hi < lo) begin span = lo; lo = hi; hi = span; end
          span = hi - lo + 1;
          lo = lo + (longint'($urandom()) % span);
          wsz = ($urandom_range(0, 3) == 0) ? 32'h0100_0000 : 32'h0004_0000;
          it = mk_query(lo[31:0], spread(wsz));
        end else begin
          it = mk_query($urandom(), $urandom());
        end
        // never let a query touch an entry that was never written
        if (it.op == OP_QUERY && !table_ready()) begin
          for (int i = 255; i >= 0; i--) if (!wp_written[i]) it = mk_load(i[7:0],
            $urandom(), $urandom(), $urandom());
        end
        send_item(it, 0, none);
      end
      phase++;
    end

    calm = 1'b0;
    drain();
    repeat (500) @(posedge clk);
    $display("covered %0d queries, %0d loads, %0d count writes over %0d phases",
             n_query, n_load, n_cfg, phase);
    $display("saturated results %0d, zero-length results %0d, mismatches %0d",
             n_sat, n_zero, errors);
    if (errors == 0 && pending_pts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
